FILE: hdl/rtd_pkg.sv
package rtd_pkg;

   localparam int WORD_W  = 16;
   localparam int CODE_W  = 15;
   localparam int TEMP_W  = 18;

   // discriminant scaled by 8192e14, signed so a negative value shows in the top bit
   localparam int E_W     = 46;
   localparam int EB_W    = 44;
   localparam int PROD_W  = 43;
   localparam int X_W     = 63;   // 2*E*2^18
   localparam int ROOT_W  = 32;
   localparam int MAG_W   = 50;   // |code - 8192| * OUT_SCALE
   localparam int W_W     = 33;   // ALPHA_SCALED + root
   localparam int NUM_W   = 52;   // 2*mag + w
   localparam int DEN_W   = 34;   // 2*w
   localparam int QUOT_W  = 17;

   localparam logic [CODE_W-1:0] CODE_ONE     = 15'd8192;
   localparam logic [EB_W-1:0]   E_BASE       = 44'd12513123442688;
   localparam logic [27:0]       FOUR_BETA    = 28'd231000000;
   localparam logic [34:0]       OUT_SCALE    = 35'd20480000000;
   localparam logic [31:0]       ALPHA_SCALED = 32'd2561343488;

   // front stage + one per root bit + divider setup + one per quotient bit + output
   localparam int LATENCY = 1 + ROOT_W + 1 + QUOT_W + 1;

   typedef struct packed {
      logic             bad;
      logic             neg;
      logic [X_W-1:0]   x;
      logic [MAG_W-1:0] mag;
   } front_type;

   typedef struct packed {
      logic              bad;
      logic              neg;
      logic [MAG_W-1:0]  mag;
      logic [ROOT_W-1:0] root;
   } root_type;

endpackage

FILE: hdl/rtd_front.sv
module rtd_front
   import rtd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [WORD_W-1:0] in_word,
   output logic              out_valid,
   output front_type         out_data
);

   logic [CODE_W-1:0]       code;
   logic                    neg;
   logic [CODE_W-1:0]       absd;
   logic [PROD_W-1:0]       prod_e;
   logic [MAG_W-1:0]        mag;
   logic signed [E_W-1:0]   e;
   front_type               data_in;
   front_type               data_ff;
   logic                    valid_ff;

   assign code = in_word[WORD_W-1:1];
   assign neg  = code < CODE_ONE;
   assign absd = neg ? (CODE_ONE - code) : (code - CODE_ONE);

   assign prod_e = {15'b0, FOUR_BETA} * {28'b0, absd};
   assign mag    = {15'b0, OUT_SCALE} * {35'b0, absd};

   // n = 8192 - code is +absd below the zero point, -absd above it
   always_comb begin
      if (neg) begin
         e = $signed({2'b0, E_BASE}) + $signed({3'b0, prod_e});
      end else begin
         e = $signed({2'b0, E_BASE}) - $signed({3'b0, prod_e});
      end
      data_in.bad = e[E_W-1];
      data_in.neg = neg;
      data_in.x   = {e[EB_W-1:0], 19'b0};
      data_in.mag = mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hdl/rtd_sqrt.sv
module rtd_sqrt
   import rtd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   input  front_type in_data,
   output logic      out_valid,
   output root_type  out_data
);

   typedef struct packed {
      logic             bad;
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [X_W-1:0]   x;
      logic [X_W-1:0]   r;
   } sq_type;

   sq_type              cur   [ROOT_W];
   sq_type              sq_in [ROOT_W];
   sq_type              sq_ff [ROOT_W];
   logic [ROOT_W-1:0]   vld_ff;

   // one root bit per stage, highest first
   for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
      localparam logic [X_W:0] BIT = {{X_W{1'b0}}, 1'b1} << (2 * (ROOT_W - 1 - s));
      logic [X_W:0] trial;
      logic         take;

      if (s == 0) begin : g_first
         always_comb begin
            cur[s].bad = in_data.bad;
            cur[s].neg = in_data.neg;
            cur[s].mag = in_data.mag;
            cur[s].x   = in_data.x;
            cur[s].r   = '0;
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else begin
               vld_ff[s] <= in_valid;
            end
         end
      end else begin : g_next
         assign cur[s] = sq_ff[s-1];
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end

      assign trial = {1'b0, cur[s].r} + BIT;
      assign take  = {1'b0, cur[s].x} >= trial;

      always_comb begin
         sq_in[s] = cur[s];
         if (take) begin
            sq_in[s].x = cur[s].x - trial[X_W-1:0];
            sq_in[s].r = (cur[s].r >> 1) + BIT[X_W-1:0];
         end else begin
            sq_in[s].r = cur[s].r >> 1;
         end
      end

      always_ff @(posedge clock) begin
         sq_ff[s] <= sq_in[s];
      end
   end

   assign out_valid     = vld_ff[ROOT_W-1];
   assign out_data.bad  = sq_ff[ROOT_W-1].bad;
   assign out_data.neg  = sq_ff[ROOT_W-1].neg;
   assign out_data.mag  = sq_ff[ROOT_W-1].mag;
   assign out_data.root = sq_ff[ROOT_W-1].r[ROOT_W-1:0];

endmodule

FILE: hdl/rtd_div.sv
module rtd_div
   import rtd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  root_type                 in_data,
   output logic                     out_valid,
   output logic signed [TEMP_W-1:0] out_temp,
   output logic                     out_bad
);

   typedef struct packed {
      logic              bad;
      logic              neg;
      logic [NUM_W-1:0]  rem;
      logic [DEN_W-1:0]  den;
      logic [QUOT_W-1:0] q;
   } ds_type;

   logic [W_W-1:0]            w;
   ds_type                    pr_in;
   ds_type                    pr_ff;
   logic                      pr_vld_ff;
   ds_type                    cur   [QUOT_W];
   ds_type                    ds_in [QUOT_W];
   ds_type                    ds_ff [QUOT_W];
   logic [QUOT_W-1:0]         vld_ff;
   logic [TEMP_W-1:0]         q_ext;
   logic signed [TEMP_W-1:0]  temp_in;
   logic signed [TEMP_W-1:0]  temp_ff;
   logic                      bad_ff;
   logic                      out_vld_ff;

   // round to nearest: q = floor((2*mag + w) / (2*w))
   assign w = {1'b0, ALPHA_SCALED} + {1'b0, in_data.root};

   always_comb begin
      pr_in.bad = in_data.bad;
      pr_in.neg = in_data.neg;
      pr_in.rem = {1'b0, in_data.mag, 1'b0} + {{(NUM_W-W_W){1'b0}}, w};
      pr_in.den = {w, 1'b0};
      pr_in.q   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_vld_ff <= 1'b0;
      end else begin
         pr_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      pr_ff <= pr_in;
   end

   // restoring division, one quotient bit per stage
   for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
      localparam int K = QUOT_W - 1 - s;
      logic [NUM_W-1:0] shifted;
      logic             take;

      if (s == 0) begin : g_first
         assign cur[s] = pr_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else begin
               vld_ff[s] <= pr_vld_ff;
            end
         end
      end else begin : g_next
         assign cur[s] = ds_ff[s-1];
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end

      assign shifted = {{(NUM_W-DEN_W){1'b0}}, cur[s].den} << K;
      assign take    = cur[s].rem >= shifted;

      always_comb begin
         ds_in[s] = cur[s];
         if (take) begin
            ds_in[s].rem  = cur[s].rem - shifted;
            ds_in[s].q[K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         ds_ff[s] <= ds_in[s];
      end
   end

   assign q_ext = {1'b0, ds_ff[QUOT_W-1].q};

   always_comb begin
      if (ds_ff[QUOT_W-1].bad) begin
         temp_in = '0;
      end else if (ds_ff[QUOT_W-1].neg) begin
         temp_in = -$signed(q_ext);
      end else begin
         temp_in = $signed(q_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[QUOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      temp_ff <= temp_in;
      bad_ff  <= ds_ff[QUOT_W-1].bad;
   end

   assign out_valid = out_vld_ff;
   assign out_temp  = temp_ff;
   assign out_bad   = bad_ff;

endmodule

FILE: hdl/rtd_code_to_temperature.sv
// Channel   Ports                                     Transfer
// input     start, busy, req_rtd_word                 edge with start high, busy low
// result    rsp_strobe, rsp_temperature, rsp_bad_root edge ending the strobe cycle
//
// One code per cycle while busy is low. After its transfer each code passes through
// one front stage (discriminant and numerator products), 32 square-root stages
// (one root bit each), one divider setup stage, 17 division stages (one quotient
// bit each) and the output register. busy is high during reset and in the cycle
// after it; reset empties the pipeline. The receiver cannot stall, so nothing backs up.
module rtd_code_to_temperature
   import rtd_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [WORD_W-1:0]        req_rtd_word,
   output logic                     rsp_strobe,
   output logic signed [TEMP_W-1:0] rsp_temperature,
   output logic                     rsp_bad_root
);

   logic       busy_ff;
   logic       accept;
   logic       fr_valid;
   front_type  fr_data;
   logic       rt_valid;
   root_type   rt_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   rtd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_word   (req_rtd_word),
      .out_valid (fr_valid),
      .out_data  (fr_data)
   );

   rtd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_data   (fr_data),
      .out_valid (rt_valid),
      .out_data  (rt_data)
   );

   rtd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rt_valid),
      .in_data   (rt_data),
      .out_valid (rsp_strobe),
      .out_temp  (rsp_temperature),
      .out_bad   (rsp_bad_root)
   );

   a_strobe_from_transfer: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result strobe without a matching input transfer");

   a_bad_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_bad_root |-> rsp_temperature == '0)
      else $error("bad root with nonzero temperature");

   a_zero_point: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(accept && req_rtd_word[WORD_W-1:1] == CODE_ONE, LATENCY)
      |-> rsp_temperature == '0)
      else $error("zero-point code did not give zero temperature");

   a_sign_below_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(accept && req_rtd_word[WORD_W-1:1] < CODE_ONE, LATENCY)
      |-> rsp_temperature[TEMP_W-1] || rsp_temperature == '0)
      else $error("code below zero point gave positive temperature");

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low right after reset");

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
   import rtd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam longint          ZERO_CODE   = 64'sd8192;
   localparam longint          DISC_BASE   = 64'sd12513123442688;  // alpha^2 term, scaled
   localparam longint          DISC_SLOPE  = 64'sd231000000;       // 4*|beta|, scaled
   localparam longint unsigned ROOT_OFFSET = 64'd2561343488;       // alpha, root scale
   localparam longint          TEMP_SCALE  = 64'sd20480000000;
   localparam int              CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [TEMP_W-1:0] temperature;
      logic              bad_root;
   } temp_result_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [WORD_W-1:0]        req_rtd_word;
   logic                     rsp_strobe;
   logic signed [TEMP_W-1:0] rsp_temperature;
   logic                     rsp_bad_root;

   temp_result_type temp_expect_q[$];
   int              err_cnt;
   int              xfer_cnt;
   int              cycle_cnt;
   int              max_gap;

   rtd_code_to_temperature i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_rtd_word    (req_rtd_word),
      .rsp_strobe      (rsp_strobe),
      .rsp_temperature (rsp_temperature),
      .rsp_bad_root    (rsp_bad_root)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned rem;
      longint unsigned acc;
      longint unsigned b;
      rem = x;
      acc = 0;
      b   = 64'h4000_0000_0000_0000;
      while (b > rem)
         b >>= 2;
      while (b != 0) begin
         if (rem >= acc + b) begin
            rem -= acc + b;
            acc = (acc >> 1) + b;
         end else begin
            acc >>= 1;
         end
         b >>= 2;
      end
      return acc;
   endfunction

   // t = -2c / (alpha + sqrt(disc)), rounded half away from zero
   function automatic temp_result_type predict_temperature(input logic [WORD_W-1:0] word);
      longint          code;
      longint          disc;
      longint          num;
      longint          t;
      longint unsigned root;
      longint unsigned w;
      longint unsigned mag;
      longint unsigned q;
      temp_result_type r;
      code = longint'(word[WORD_W-1:1]);
      disc = DISC_BASE + DISC_SLOPE * (ZERO_CODE - code);
      if (disc < 0) begin
         r.temperature = '0;
         r.bad_root    = 1'b1;
         return r;
      end
      root = floor_sqrt(($unsigned(disc) * 2) << 18);
      w    = ROOT_OFFSET + root;
      num  = (code - ZERO_CODE) * TEMP_SCALE;
      mag  = (num < 0) ? $unsigned(-num) : $unsigned(num);
      q    = (mag * 2 + w) / (w * 2);
      t    = (num < 0) ? -$signed(q) : $signed(q);
      r.temperature = t[TEMP_W-1:0];
      r.bad_root    = 1'b0;
      return r;
   endfunction

   // transfer capture and result check, both on the rising edge
   always @(posedge clock) begin
      temp_result_type exp_r;
      if (!reset) begin
         if (rsp_strobe) begin
            if (temp_expect_q.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual temp %0d bad %0b",
                        $realtime, rsp_temperature, rsp_bad_root);
               err_cnt++;
            end else begin
               exp_r = temp_expect_q.pop_front();
               if (rsp_temperature !== exp_r.temperature) begin
                  $display("%0t: temperature mismatch: expected %0d actual %0d",
                           $realtime, $signed(exp_r.temperature), rsp_temperature);
                  err_cnt++;
               end
               if (rsp_bad_root !== exp_r.bad_root) begin
                  $display("%0t: bad_root mismatch: expected %0b actual %0b",
                           $realtime, exp_r.bad_root, rsp_bad_root);
                  err_cnt++;
               end
            end
         end
         if (start && !busy) begin
            temp_expect_q.push_back(predict_temperature(req_rtd_word));
            xfer_cnt++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("%0t: timeout", $realtime);
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // caller is at a falling edge; returns at a falling edge
   task automatic send_word(input logic [WORD_W-1:0] word);
      int target;
      int gap;
      target       = xfer_cnt + 1;
      start        = 1'b1;
      req_rtd_word = word;
      do
         @(negedge clock);
      while (xfer_cnt != target);
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic test_code_extremes();
      logic [WORD_W-1:0] words[] = '{16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE,
                                     16'h0002, 16'h0003, 16'hFFFC, 16'h8000,
                                     16'h7FFF, 16'hAAAA, 16'h5555};
      max_gap = 2;
      foreach (words[i])
         send_word(words[i]);
   endtask

   // code 8192 is exactly 500 ohm, so 0 degC; neighbors straddle the sign change
   task automatic test_zero_point();
      logic [CODE_W-1:0] codes[] = '{15'd8191, 15'd8192, 15'd8193};
      max_gap = 1;
      foreach (codes[i]) begin
         send_word({codes[i], 1'b0});
         send_word({codes[i], 1'b1});
      end
   endtask

   // fault bit must not change the result
   task automatic test_fault_bit();
      logic [CODE_W-1:0] code;
      max_gap = 0;
      repeat (3) begin
         code = CODE_W'($urandom_range(0, 32767));
         send_word({code, 1'b0});
         send_word({code, 1'b1});
      end
   endtask

   task automatic test_random_codes();
      int                sel;
      logic [CODE_W-1:0] code;
      for (int i = 0; i < 400; i++) begin
         // every 50 codes the gap limit is redrawn, giving full-rate bursts or idle stretches
         if (i % 50 == 0)
            case ($urandom_range(0, 2))
               0: max_gap = 0;
               1: max_gap = 2;
               default: max_gap = 6;
            endcase
         sel = $urandom_range(0, 99);
         if (sel < 50)
            code = CODE_W'($urandom_range(0, 32767));
         else if (sel < 70)
            code = CODE_W'($urandom_range(8192 - 64, 8192 + 64));
         else if (sel < 78)
            code = CODE_W'($urandom_range(0, 63));
         else if (sel < 86)
            code = CODE_W'($urandom_range(32704, 32767));
         else
            code = 15'(1) << $urandom_range(0, CODE_W - 1);
         send_word({code, 1'($urandom_range(0, 1))});
      end
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_rtd_word = '0;
      err_cnt      = 0;
      xfer_cnt     = 0;
      cycle_cnt    = 0;
      max_gap      = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      test_code_extremes();
      test_zero_point();
      test_fault_bit();
      test_random_codes();
      start = 1'b0;

      while (temp_expect_q.size() != 0)
         @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);

      if (err_cnt == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
